>>> hw/rtl/pda_pkg.sv
package pda_pkg;

  localparam int CHAR_W          = 8;
  localparam int AMOUNT_W        = 60;
  localparam int WHOLE_DIGITS    = 10;
  localparam int FRACTION_DIGITS = 8;
  localparam int COUNT_W         = 4;
  localparam int WHOLE_TERM_W    = 30;
  localparam int FRAC_TERM_W     = 27;
  localparam int FRAC_WEIGHT_W   = 24;

  localparam logic [WHOLE_TERM_W-1:0] UNITS_PER_WHOLE = 30'd100000000;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // Space, tab, LF, VT, FF and CR.
  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  // Weight of a fraction digit in 1e-8 units, by its place after the point.
  function automatic logic [FRAC_WEIGHT_W-1:0] frac_weight(input logic [2:0] pos);
    logic [FRAC_WEIGHT_W-1:0] w;
    case (pos)
      3'd0:    w = 24'd10000000;
      3'd1:    w = 24'd1000000;
      3'd2:    w = 24'd100000;
      3'd3:    w = 24'd10000;
      3'd4:    w = 24'd1000;
      3'd5:    w = 24'd100;
      3'd6:    w = 24'd10;
      default: w = 24'd1;
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/pda_in_if.sv
interface pda_in_if;
  logic                        valid;
  logic                        ready;
  logic [pda_pkg::CHAR_W-1:0]  character;
  logic                        end_of_text;

  modport source (output valid, output character, output end_of_text, input ready);
  modport sink (input valid, input character, input end_of_text, output ready);
endinterface

>>> hw/rtl/pda_out_if.sv
interface pda_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [pda_pkg::AMOUNT_W-1:0]  amount;

  modport source (output valid, output ok, output amount, input ready);
  modport sink (input valid, input ok, input amount, output ready);
endinterface

>>> hw/rtl/parse_decimal_amount_core.sv
// Channel   Dir  Payload                       Notes
// item      in   character[7:0], end_of_text   one text byte, or the end mark
// result    out  ok, amount[59:0]              one beat per end mark
//
// One beat can be taken every cycle unless the input stalls. A text byte is parsed at
// the edge after it is taken; an end beat loads its result beat at the edge it is parsed.
// An end beat waits in the input register while the result register is full and not
// being drained, and the input stalls for that time; text bytes never wait.
// rst is synchronous; it clears both valid flags and returns the parser to the
// leading whitespace phase.
module parse_decimal_amount_core (
  input  logic          clk,
  input  logic          rst,
  pda_in_if.sink        item,
  pda_out_if.source     result
);

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_WHOLE,
    PH_FRAC,
    PH_TRAIL,
    PH_FAIL
  } phase_t;

  // Input register.
  logic                          in_valid;
  logic [pda_pkg::CHAR_W-1:0]    in_char;
  logic                          in_end;

  // Parser state. The whole part is accumulated directly in 1e-8 units.
  phase_t                        phase, phase_next;
  logic [pda_pkg::AMOUNT_W-1:0]  acc, acc_next;
  logic [pda_pkg::COUNT_W-1:0]   whole_count, whole_count_next;
  logic [pda_pkg::COUNT_W-1:0]   frac_pos, frac_pos_next;

  // Result register.
  logic                          out_valid;
  logic                          out_ok;
  logic [pda_pkg::AMOUNT_W-1:0]  out_amount;

  logic                          advance;
  logic                          digit;
  logic                          blank;
  logic [3:0]                    digit_val;
  logic [pda_pkg::WHOLE_TERM_W-1:0] whole_term;
  logic [pda_pkg::FRAC_TERM_W-1:0]  frac_term;
  logic [pda_pkg::AMOUNT_W-1:0]  acc_times_ten;

  assign advance     = in_valid && (!in_end || !out_valid || result.ready);
  assign item.ready  = !in_valid || advance;

  assign result.valid  = out_valid;
  assign result.ok     = out_ok;
  assign result.amount = out_amount;

  assign digit     = pda_pkg::is_digit(in_char);
  assign blank     = pda_pkg::is_blank(in_char);
  assign digit_val = 4'(in_char - pda_pkg::CHAR_ZERO);
  assign whole_term = pda_pkg::WHOLE_TERM_W'(digit_val) * pda_pkg::UNITS_PER_WHOLE;
  assign frac_term  = pda_pkg::FRAC_TERM_W'(digit_val) *
                      pda_pkg::FRAC_TERM_W'(pda_pkg::frac_weight(frac_pos[2:0]));
  assign acc_times_ten = {acc[pda_pkg::AMOUNT_W-4:0], 3'b000} +
                         {acc[pda_pkg::AMOUNT_W-2:0], 1'b0};

  always_comb begin
    phase_next       = phase;
    acc_next         = acc;
    whole_count_next = whole_count;
    frac_pos_next    = frac_pos;
    case (phase)
      PH_LEAD, PH_WHOLE: begin
        if (digit) begin
          if (whole_count >= pda_pkg::COUNT_W'(pda_pkg::WHOLE_DIGITS)) begin
            phase_next = PH_FAIL;
          end else begin
            acc_next         = acc_times_ten + pda_pkg::AMOUNT_W'(whole_term);
            whole_count_next = whole_count + 1'b1;
            phase_next       = PH_WHOLE;
          end
        end else if (in_char == pda_pkg::CHAR_POINT) begin
          phase_next = PH_FRAC;
        end else if (blank) begin
          phase_next = (phase == PH_LEAD) ? PH_LEAD : PH_TRAIL;
        end else begin
          phase_next = PH_FAIL;
        end
      end
      PH_FRAC: begin
        if (digit) begin
          if (frac_pos >= pda_pkg::COUNT_W'(pda_pkg::FRACTION_DIGITS)) begin
            phase_next = PH_FAIL;
          end else begin
            acc_next      = acc + pda_pkg::AMOUNT_W'(frac_term);
            frac_pos_next = frac_pos + 1'b1;
          end
        end else if (blank) begin
          phase_next = PH_TRAIL;
        end else begin
          phase_next = PH_FAIL;
        end
      end
      PH_TRAIL: begin
        if (!blank) begin
          phase_next = PH_FAIL;
        end
      end
      default: begin
        phase_next = PH_FAIL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      out_valid   <= 1'b0;
      phase       <= PH_LEAD;
      acc         <= '0;
      whole_count <= '0;
      frac_pos    <= '0;
    end else begin
      if (item.ready) begin
        in_valid <= item.valid;
      end
      if (advance && in_end) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        if (in_end) begin
          phase       <= PH_LEAD;
          acc         <= '0;
          whole_count <= '0;
          frac_pos    <= '0;
        end else begin
          phase       <= phase_next;
          acc         <= acc_next;
          whole_count <= whole_count_next;
          frac_pos    <= frac_pos_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      in_char <= item.character;
      in_end  <= item.end_of_text;
    end
    if (advance && in_end) begin
      out_ok     <= (phase != PH_FAIL);
      out_amount <= (phase != PH_FAIL) ? acc : '0;
    end
  end

  a_fail_amount_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ok) |-> (out_amount == '0))
    else $error("failed parse reported a nonzero amount");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    (advance && in_end) |=> (phase == PH_LEAD && acc == '0 &&
                             whole_count == '0 && frac_pos == '0))
    else $error("parser state not cleared after end beat");

  a_text_no_result: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && advance && !in_end) |=> !out_valid)
    else $error("text byte produced a result");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (whole_count <= pda_pkg::COUNT_W'(pda_pkg::WHOLE_DIGITS)) &&
    (frac_pos <= pda_pkg::COUNT_W'(pda_pkg::FRACTION_DIGITS)))
    else $error("digit count out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (in_valid && in_end && out_valid && !result.ready))
    else $error("input stalled without a blocked end beat");

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int TEXT_BEATS    = 850;
  localparam int HOLD_AT       = 25;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 20;
  localparam int REPORT_MAX    = 10;
  localparam int MAX_WAIT      = 6;

  typedef enum logic [2:0] {
    SCAN_LEAD,
    SCAN_WHOLE,
    SCAN_FRAC,
    SCAN_TRAIL,
    SCAN_BAD
  } scan_phase_t;

  typedef struct packed {
    logic                         ok;
    logic [pda_pkg::AMOUNT_W-1:0] amount;
  } amount_result_t;

  typedef struct {
    string                        text;
    int                           nul_at;
    bit                           typed;
    bit                           want_ok;
    logic [pda_pkg::AMOUNT_W-1:0] want_amount;
  } text_case_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  pda_in_if  item_bus ();
  pda_out_if result_bus ();

  parse_decimal_amount_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  // Rows marked typed carry their result; the others are checked against the parser model.
  text_case_t directed_texts [0:17] = '{
    '{"",                    -1, 1'b1, 1'b1, 60'd0},
    '{" \t\n\013\014\015",   -1, 1'b1, 1'b1, 60'd0},
    '{".",                   -1, 1'b1, 1'b1, 60'd0},
    '{".5",                  -1, 1'b1, 1'b1, 60'd50000000},
    '{"9999999999.99999999", -1, 1'b1, 1'b1, 60'd999999999999999999},
    '{"12345678901",         -1, 1'b1, 1'b0, 60'd0},
    '{"1.123456789",         -1, 1'b1, 1'b0, 60'd0},
    '{"1.2.3",               -1, 1'b1, 1'b0, 60'd0},
    '{"-1",                  -1, 1'b1, 1'b0, 60'd0},
    '{"+5",                  -1, 1'b1, 1'b0, 60'd0},
    '{"1 2",                 -1, 1'b1, 1'b0, 60'd0},
    '{"1",                    1, 1'b1, 1'b0, 60'd0},
    '{"\377",                -1, 1'b1, 1'b0, 60'd0},
    '{"0000000000",          -1, 1'b1, 1'b1, 60'd0},
    '{"  42  ",              -1, 1'b0, 1'b0, 60'd0},
    '{"007.250\t",           -1, 1'b0, 1'b0, 60'd0},
    '{"5.",                  -1, 1'b0, 1'b0, 60'd0},
    '{"1234567890",          -1, 1'b0, 1'b0, 60'd0}
  };

  scan_phase_t                     scan_phase = SCAN_LEAD;
  logic [33:0]                     whole_acc = '0;
  logic [pda_pkg::COUNT_W-1:0]     whole_count = '0;
  logic [pda_pkg::FRAC_TERM_W-1:0] frac_acc = '0;
  logic [pda_pkg::COUNT_W-1:0]     frac_count = '0;

  amount_result_t                  pending_amounts [$];
  logic [pda_pkg::CHAR_W-1:0]      text_bytes [$];
  int                              mismatches = 0;
  int                              stray_results = 0;
  int                              results_seen = 0;
  int                              beats_sent = 0;
  int                              cycle_count = 0;
  bit                              tx_steady = 1'b0;
  bit                              rx_steady = 1'b0;

  function automatic bit is_space_char(input logic [pda_pkg::CHAR_W-1:0] c);
    return (c == pda_pkg::CHAR_SPACE) ||
           (c inside {[pda_pkg::CHAR_TAB:pda_pkg::CHAR_CR]});
  endfunction

  function automatic bit is_decimal_char(input logic [pda_pkg::CHAR_W-1:0] c);
    return c inside {[pda_pkg::CHAR_ZERO:pda_pkg::CHAR_NINE]};
  endfunction

  function automatic void add_text_byte(input logic [pda_pkg::CHAR_W-1:0] b);
    text_bytes = {text_bytes, b};
  endfunction

  function automatic void absorb_char(input logic [pda_pkg::CHAR_W-1:0] c);
    logic [pda_pkg::FRAC_TERM_W-1:0] weight;
    logic [pda_pkg::CHAR_W-1:0]      digit;
    digit = c - pda_pkg::CHAR_ZERO;
    case (scan_phase)
      SCAN_LEAD, SCAN_WHOLE: begin
        if (is_decimal_char(c)) begin
          if (whole_count >= pda_pkg::WHOLE_DIGITS) begin
            scan_phase = SCAN_BAD;
          end else begin
            whole_acc   = whole_acc * 34'd10 + {26'd0, digit};
            whole_count = whole_count + 1'b1;
            scan_phase  = SCAN_WHOLE;
          end
        end else if (c == pda_pkg::CHAR_POINT) begin
          scan_phase = SCAN_FRAC;
        end else if (is_space_char(c)) begin
          scan_phase = (scan_phase == SCAN_LEAD) ? SCAN_LEAD : SCAN_TRAIL;
        end else begin
          scan_phase = SCAN_BAD;
        end
      end
      SCAN_FRAC: begin
        if (is_decimal_char(c)) begin
          if (frac_count >= pda_pkg::FRACTION_DIGITS) begin
            scan_phase = SCAN_BAD;
          end else begin
            weight = 27'd1;
            for (int k = frac_count; k < pda_pkg::FRACTION_DIGITS - 1; k++) begin
              weight = weight * 27'd10;
            end
            frac_acc   = frac_acc + weight * {19'd0, digit};
            frac_count = frac_count + 1'b1;
          end
        end else if (is_space_char(c)) begin
          scan_phase = SCAN_TRAIL;
        end else begin
          scan_phase = SCAN_BAD;
        end
      end
      SCAN_TRAIL: begin
        if (!is_space_char(c)) begin
          scan_phase = SCAN_BAD;
        end
      end
      default: begin
        scan_phase = SCAN_BAD;
      end
    endcase
  endfunction

  // Closes the current text: yields its amount and clears the parser state.
  function automatic amount_result_t close_text();
    amount_result_t r;
    if (scan_phase == SCAN_BAD) begin
      r.ok     = 1'b0;
      r.amount = '0;
    end else begin
      r.ok     = 1'b1;
      r.amount = {26'd0, whole_acc} * 60'd100000000 + {33'd0, frac_acc};
    end
    scan_phase  = SCAN_LEAD;
    whole_acc   = '0;
    whole_count = '0;
    frac_acc    = '0;
    frac_count  = '0;
    return r;
  endfunction

  function automatic logic [pda_pkg::CHAR_W-1:0] random_blank();
    if ($urandom_range(0, 1) == 0) begin
      return pda_pkg::CHAR_SPACE;
    end
    return pda_pkg::CHAR_TAB + pda_pkg::CHAR_W'($urandom_range(0, 4));
  endfunction

  function automatic logic [pda_pkg::CHAR_W-1:0] random_digit();
    return pda_pkg::CHAR_ZERO + pda_pkg::CHAR_W'($urandom_range(0, 9));
  endfunction

  function automatic logic [pda_pkg::CHAR_W-1:0] random_byte();
    return pda_pkg::CHAR_W'($urandom_range(0, 255));
  endfunction

  task automatic offer_beat(input logic [pda_pkg::CHAR_W-1:0] c, input bit eot,
                            input bit typed = 1'b0,
                            input bit want_ok = 1'b0,
                            input logic [pda_pkg::AMOUNT_W-1:0] want_amount = '0);
    int             gap;
    amount_result_t r;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid       <= 1'b1;
    item_bus.character   <= c;
    item_bus.end_of_text <= eot;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    beats_sent++;
    if (!eot) begin
      absorb_char(c);
    end else begin
      r = close_text();
      if (typed) begin
        r.ok     = want_ok;
        r.amount = want_amount;
      end
      pending_amounts = {pending_amounts, r};
    end
  endtask

  // Mostly well-formed amounts, with an occasional flaw spliced in.
  task automatic build_random_text();
    int n_whole;
    int n_frac;
    int spot;
    text_bytes.delete();
    repeat ($urandom_range(0, 2)) add_text_byte(random_blank());
    n_whole = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 4);
    repeat (n_whole) add_text_byte(random_digit());
    if ($urandom_range(0, 9) < 7) begin
      add_text_byte(pda_pkg::CHAR_POINT);
      n_frac = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 9) : $urandom_range(0, 4);
      repeat (n_frac) add_text_byte(random_digit());
    end
    repeat ($urandom_range(0, 2)) add_text_byte(random_blank());
    spot = $urandom_range(0, text_bytes.size());
    case ($urandom_range(0, 9))
      0: text_bytes.insert(spot, random_byte());
      1: text_bytes.insert(spot, pda_pkg::CHAR_POINT);
      2: begin
        if (text_bytes.size() != 0) begin
          text_bytes[spot % text_bytes.size()] = random_byte();
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result(input logic ok, input logic [pda_pkg::AMOUNT_W-1:0] amount);
    amount_result_t want;
    if (pending_amounts.size() == 0) begin
      stray_results++;
      if (mismatches + stray_results <= REPORT_MAX) begin
        $display("unexpected result beat: ok=%0b amount=%0d", ok, amount);
      end
    end else begin
      want = pending_amounts.pop_front();
      if (ok !== want.ok || amount !== want.amount) begin
        mismatches++;
        if (mismatches + stray_results <= REPORT_MAX) begin
          $display("result %0d: expected ok=%0b amount=%0d, got ok=%0b amount=%0d",
                   results_seen, want.ok, want.amount, ok, amount);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random stalls, steady stretches, and one long hold-off.
  initial begin
    int gap;
    result_bus.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) begin
        rx_steady = !rx_steady;
      end
      gap = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap != 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      @(posedge clk);
      while (!result_bus.valid) @(posedge clk);
      check_result(result_bus.ok, result_bus.amount);
      results_seen++;
      if (results_seen == HOLD_AT) begin
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  initial begin
    int failures;
    item_bus.valid       <= 1'b0;
    item_bus.character   <= '0;
    item_bus.end_of_text <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_texts[n]) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i <= directed_texts[n].text.len(); i++) begin
        if (i == directed_texts[n].nul_at) begin
          offer_beat(8'h00, 1'b0);
        end
        if (i < directed_texts[n].text.len()) begin
          offer_beat(directed_texts[n].text[i], 1'b0);
        end
      end
      offer_beat(random_byte(), 1'b1, directed_texts[n].typed,
                 directed_texts[n].want_ok, directed_texts[n].want_amount);
    end

    while (beats_sent < TEXT_BEATS) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      build_random_text();
      foreach (text_bytes[k]) begin
        offer_beat(text_bytes[k], 1'b0);
      end
      offer_beat(random_byte(), 1'b1);
    end
    item_bus.valid <= 1'b0;

    while (pending_amounts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    failures = mismatches + stray_results + pending_amounts.size();
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
